// ----- hw/rtl/radial_vignette_pixel_assert.svh -----
// ----------------------------------------------------------------------------
// radial vignette assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef RADIAL_VIGNETTE_PIXEL_ASSERT_SVH
`define RADIAL_VIGNETTE_PIXEL_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RVP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rvp port check failed");

// next-cycle implication, sampled on clk, off during reset
`define RVP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rvp port check failed");

`endif

// ----- hw/rtl/rvp_pkg.sv -----
// ----------------------------------------------------------------------------
// rvp_pkg
// shared types and constants of the radial vignette pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rvp_pkg;

	localparam int DIM_W   = 13;
	localparam int POS_W   = 12;
	localparam int CH_W    = 8;
	localparam int RAD_W   = 26;
	localparam int REM_W   = 16;
	localparam int ROOT_W  = 13;
	localparam int NUM_W   = 21;
	localparam int SQRT_N  = 13;
	localparam int DIV_N   = 8;

	localparam logic REG_HEIGHT = 1'b0;
	localparam logic REG_WIDTH  = 1'b1;

	typedef struct packed {
		logic [DIM_W-1:0] h;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
	} rvp_pix_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		rvp_pix_t          pix;
	} rvp_sqrt_t;

	typedef struct packed {
		logic [DIM_W-1:0]           h;
		logic [2:0][NUM_W-1:0]      rem;
		logic [2:0][CH_W-1:0]       quo;
	} rvp_div_t;

endpackage

`default_nettype wire

// ----- hw/rtl/radial_vignette_pixel.sv -----
// ----------------------------------------------------------------------------
// radial_vignette_pixel
// radial vignette with linear falloff, one pixel per beat
// ----------------------------------------------------------------------------
// Takes one pixel per cycle when the output is not stalled and presents it at
// the output through 25 register stages: a front stage for the centre
// offsets, a squaring stage, a sum stage, a row of 13 square-root cells (one
// root bit each), a scaling multiply, and a row of 8 divider cells (one
// quotient bit each, three channels side by side). Each stage holds its
// beat until the next one frees, so bubbles collapse and input is taken while
// a result waits at the output if any stage is empty. Height and width are
// clamped to 1..MAX_DIM; a distance at or beyond the height gives black.
`default_nettype none

module radial_vignette_pixel #(
	parameter int MAX_DIM = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [11:0] pixel_row,
	input  wire logic [11:0] pixel_col,
	input  wire logic [7:0]  red_in,
	input  wire logic [7:0]  green_in,
	input  wire logic [7:0]  blue_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       red_out,
	output logic [7:0]       green_out,
	output logic [7:0]       blue_out
);

	localparam int DW = rvp_pkg::DIM_W;
	localparam int PW = rvp_pkg::POS_W;
	localparam logic [DW-1:0] DIM_CAP = (MAX_DIM > 8191) ? DW'(8191) : DW'(MAX_DIM);
	localparam int SQ0 = 3;
	localparam int MUL = SQ0 + rvp_pkg::SQRT_N;
	localparam int DV0 = MUL + 1;
	localparam int NST = DV0 + rvp_pkg::DIV_N;

	logic [DW-1:0] height_q, width_q;
	logic [DW-1:0] h_c, w_c;
	logic [NST-1:0] v_q;
	logic [NST:0]   adv;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= DW'(1);
			width_q  <= DW'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				rvp_pkg::REG_HEIGHT: height_q <= cfg_data;
				rvp_pkg::REG_WIDTH:  width_q  <= cfg_data;
			endcase
		end
	end

	always_comb begin
		h_c = (height_q == '0) ? DW'(1) : ((height_q > DIM_CAP) ? DIM_CAP : height_q);
		w_c = (width_q == '0) ? DW'(1) : ((width_q > DIM_CAP) ? DIM_CAP : width_q);
	end

	// stage advance: a stage moves when empty or when its successor moves
	always_comb begin
		adv[NST] = out_ready;
		for (int i = NST - 1; i >= 0; i--) begin
			adv[i] = !v_q[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0]) begin
				v_q[0] <= in_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (adv[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = v_q[NST-1];

	// front: offsets from centre
	logic [PW-1:0] half_w, half_h, dx_c, dy_c;
	logic [PW-1:0] dx_s1, dy_s1;
	rvp_pkg::rvp_pix_t pix_s1, pix_s2, pix_s3;
	logic [2*PW-1:0] sqx_s2, sqy_s2;
	logic [rvp_pkg::RAD_W-1:0] sum_s3;

	always_comb begin
		half_w = w_c[DW-1:1];
		half_h = h_c[DW-1:1];
		dx_c = (pixel_col >= half_w) ? (pixel_col - half_w) : (half_w - pixel_col);
		dy_c = (pixel_row >= half_h) ? (pixel_row - half_h) : (half_h - pixel_row);
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			dx_s1  <= dx_c;
			dy_s1  <= dy_c;
			pix_s1 <= '{h: h_c, red: red_in, green: green_in, blue: blue_in};
		end
		if (adv[1]) begin
			sqx_s2 <= (2*PW)'(dx_s1) * (2*PW)'(dx_s1);
			sqy_s2 <= (2*PW)'(dy_s1) * (2*PW)'(dy_s1);
			pix_s2 <= pix_s1;
		end
		if (adv[2]) begin
			sum_s3 <= rvp_pkg::RAD_W'(sqx_s2) + rvp_pkg::RAD_W'(sqy_s2);
			pix_s3 <= pix_s2;
		end
	end

	// square-root cell row
	rvp_pkg::rvp_sqrt_t sq_d [rvp_pkg::SQRT_N+1];

	assign sq_d[0] = '{rad: sum_s3, rem: '0, root: '0, pix: pix_s3};

	for (genvar g = 0; g < rvp_pkg::SQRT_N; g++) begin : g_sqrt
		rvp_sqrt_cell u_cell (
			.clk (clk),
			.en  (adv[SQ0+g]),
			.d   (sq_d[g]),
			.q   (sq_d[g+1])
		);
	end

	// scale: c * (h - d), zero when d reaches h
	rvp_pkg::rvp_pix_t  pix_m;
	logic [DW-1:0]      dist_m, span_m;
	rvp_pkg::rvp_div_t  dv_d [rvp_pkg::DIV_N+1];

	always_comb begin
		pix_m  = sq_d[rvp_pkg::SQRT_N].pix;
		dist_m = sq_d[rvp_pkg::SQRT_N].root;
		span_m = (dist_m >= pix_m.h) ? '0 : (pix_m.h - dist_m);
	end

	always_ff @(posedge clk) begin
		if (adv[MUL]) begin
			dv_d[0].h      <= pix_m.h;
			dv_d[0].rem[0] <= rvp_pkg::NUM_W'(pix_m.red) * rvp_pkg::NUM_W'(span_m);
			dv_d[0].rem[1] <= rvp_pkg::NUM_W'(pix_m.green) * rvp_pkg::NUM_W'(span_m);
			dv_d[0].rem[2] <= rvp_pkg::NUM_W'(pix_m.blue) * rvp_pkg::NUM_W'(span_m);
			dv_d[0].quo    <= '0;
		end
	end

	// divider cell row, most significant quotient bit first
	for (genvar g = 0; g < rvp_pkg::DIV_N; g++) begin : g_div
		rvp_div_cell #(
			.SHIFT (rvp_pkg::DIV_N - 1 - g)
		) u_cell (
			.clk (clk),
			.en  (adv[DV0+g]),
			.d   (dv_d[g]),
			.q   (dv_d[g+1])
		);
	end

	assign red_out   = dv_d[rvp_pkg::DIV_N].quo[0];
	assign green_out = dv_d[rvp_pkg::DIV_N].quo[1];
	assign blue_out  = dv_d[rvp_pkg::DIV_N].quo[2];

endmodule

`default_nettype wire

// ----- hw/rtl/rvp_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// rvp_sqrt_cell
// one digit step of the integer square root, two radicand bits per cell
// ----------------------------------------------------------------------------
`default_nettype none

module rvp_sqrt_cell (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire rvp_pkg::rvp_sqrt_t d,
	output rvp_pkg::rvp_sqrt_t     q
);

	rvp_pkg::rvp_sqrt_t nxt;
	logic [rvp_pkg::REM_W-1:0] rem_sh;
	logic [rvp_pkg::REM_W-1:0] trial;

	always_comb begin
		nxt    = d;
		rem_sh = {d.rem[rvp_pkg::REM_W-3:0], d.rad[rvp_pkg::RAD_W-1 -: 2]};
		trial  = rvp_pkg::REM_W'({d.root, 2'b01});
		nxt.rad = {d.rad[rvp_pkg::RAD_W-3:0], 2'b00};
		if (rem_sh >= trial) begin
			nxt.rem  = rem_sh - trial;
			nxt.root = {d.root[rvp_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = rem_sh;
			nxt.root = {d.root[rvp_pkg::ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rvp_div_cell.sv -----
// ----------------------------------------------------------------------------
// rvp_div_cell
// one quotient bit of the restoring divide, for all three channels
// ----------------------------------------------------------------------------
`default_nettype none

module rvp_div_cell #(
	parameter int SHIFT = 7
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire rvp_pkg::rvp_div_t d,
	output rvp_pkg::rvp_div_t    q
);

	rvp_pkg::rvp_div_t nxt;
	logic [rvp_pkg::NUM_W-1:0] trial;

	always_comb begin
		nxt   = d;
		trial = rvp_pkg::NUM_W'(d.h) << SHIFT;
		for (int c = 0; c < 3; c++) begin
			if (d.rem[c] >= trial) begin
				nxt.rem[c] = d.rem[c] - trial;
				nxt.quo[c] = {d.quo[c][rvp_pkg::CH_W-2:0], 1'b1};
			end else begin
				nxt.quo[c] = {d.quo[c][rvp_pkg::CH_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rvp_checker.sv -----
// ----------------------------------------------------------------------------
// rvp_checker
// port-level checks on the vignette pipeline handshakes
// ----------------------------------------------------------------------------
`default_nettype none

`include "radial_vignette_pixel_assert.svh"

module rvp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] red_out,
	input wire logic [7:0] green_out,
	input wire logic [7:0] blue_out
);

	`RVP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
	`RVP_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable({red_out, green_out, blue_out}))
	// an empty output slot frees every stage behind it
	`RVP_ASSERT_IMP(a_empty_ready, !out_valid, in_ready)
	`RVP_ASSERT_IMP(a_drain_ready, out_ready, in_ready)

endmodule

bind radial_vignette_pixel rvp_checker u_chk (.*);

`default_nettype wire

// ----- tb/radial_vignette_pixel_tb.sv -----
// ----------------------------------------------------------------------------
// radial_vignette_pixel_tb
// drives random and corner pixels through the vignette pipeline under several
// image sizes, with random gaps and output stalls, and compares every output
// beat against an in-bench integer model of the linear radial falloff
// ----------------------------------------------------------------------------
`default_nettype none

module radial_vignette_pixel_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM = 4096;
	localparam int PIPE_LAT = 25;

	typedef struct packed {
		logic [rvp_pkg::POS_W-1:0] row;
		logic [rvp_pkg::POS_W-1:0] col;
		logic [rvp_pkg::CH_W-1:0]  r;
		logic [rvp_pkg::CH_W-1:0]  g;
		logic [rvp_pkg::CH_W-1:0]  b;
	} pixel_t;

	typedef struct packed {
		logic [rvp_pkg::CH_W-1:0] r;
		logic [rvp_pkg::CH_W-1:0] g;
		logic [rvp_pkg::CH_W-1:0] b;
	} shade_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [12:0]      cfg_data;
	logic             in_valid;
	logic             in_ready;
	logic [11:0]      pixel_row;
	logic [11:0]      pixel_col;
	logic [7:0]       red_in;
	logic [7:0]       green_in;
	logic [7:0]       blue_in;
	logic             out_valid;
	logic             out_ready;
	logic [7:0]       red_out;
	logic [7:0]       green_out;
	logic [7:0]       blue_out;

	radial_vignette_pixel #(.MAX_DIM(MAX_DIM)) u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel_row(pixel_row), .pixel_col(pixel_col),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out)
	);

	pixel_t pending_pixels[$];
	shade_t expected_shades[$];
	logic [12:0] height_reg, width_reg;
	bit no_idle;
	int errors;

	always #5 clk = ~clk;

	function automatic int unsigned eff_dim(logic [12:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return 32'(v);
	endfunction

	function automatic int unsigned int_sqrt(longint unsigned v);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return 32'(lo);
	endfunction

	function automatic shade_t vignette_shade(pixel_t p);
		int unsigned h, w, d;
		longint unsigned dx, dy;
		shade_t s;
		h = eff_dim(height_reg);
		w = eff_dim(width_reg);
		dx = (p.col >= w / 2) ? p.col - w / 2 : w / 2 - p.col;
		dy = (p.row >= h / 2) ? p.row - h / 2 : h / 2 - p.row;
		d = int_sqrt(dx * dx + dy * dy);
		if (d >= h) return '0;
		s.r = rvp_pkg::CH_W'((p.r * (h - d)) / h);
		s.g = rvp_pkg::CH_W'((p.g * (h - d)) / h);
		s.b = rvp_pkg::CH_W'((p.b * (h - d)) / h);
		return s;
	endfunction

	// driver: the predicted shade is queued when the beat is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_shades.push_back(vignette_shade({pixel_row, pixel_col,
					red_in, green_in, blue_in}));
			end
			if (!in_valid || in_ready) begin
				if (pending_pixels.size() > 0 &&
						(no_idle || $urandom_range(99) >= 29)) begin
					pixel_t p;
					p = pending_pixels.pop_front();
					in_valid  <= 1'b1;
					pixel_row <= p.row;
					pixel_col <= p.col;
					red_in    <= p.r;
					green_in  <= p.g;
					blue_in   <= p.b;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_shades.size() == 0) begin
					$error("output beat with no pixel outstanding");
					errors++;
				end else begin
					shade_t e;
					e = expected_shades.pop_front();
					if (red_out !== e.r) begin
						$error("red_out expected %0d actual %0d", e.r, red_out);
						errors++;
					end
					if (green_out !== e.g) begin
						$error("green_out expected %0d actual %0d", e.g, green_out);
						errors++;
					end
					if (blue_out !== e.b) begin
						$error("blue_out expected %0d actual %0d", e.b, blue_out);
						errors++;
					end
				end
			end
			out_ready <= no_idle || $urandom_range(99) >= 29;
		end
	end

	task automatic add_pixel(int row, int col, int r, int g, int b);
		pixel_t p;
		p.row = rvp_pkg::POS_W'(row);
		p.col = rvp_pkg::POS_W'(col);
		p.r = rvp_pkg::CH_W'(r);
		p.g = rvp_pkg::CH_W'(g);
		p.b = rvp_pkg::CH_W'(b);
		pending_pixels.push_back(p);
	endtask

	task automatic drain_pipe();
		while (pending_pixels.size() > 0 || in_valid || expected_shades.size() > 0)
			@(posedge clk);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [12:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == rvp_pkg::REG_HEIGHT) height_reg = v;
		else width_reg = v;
		@(posedge clk);
	endtask

	task automatic random_pixels(int n, int hspan, int wspan);
		repeat (n) begin
			if ($urandom_range(3) == 0)
				add_pixel($urandom_range(4095), $urandom_range(4095),
					$urandom_range(255), $urandom_range(255), $urandom_range(255));
			else
				add_pixel($urandom_range(hspan), $urandom_range(wspan),
					$urandom_range(255), $urandom_range(255), $urandom_range(255));
		end
	endtask

	initial begin
		int hs[10];
		int ws[10];
		clk = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = rvp_pkg::REG_HEIGHT;
		cfg_data = 0;
		pixel_row = 0;
		pixel_col = 0;
		red_in = 0;
		green_in = 0;
		blue_in = 0;
		height_reg = 1;
		width_reg = 1;
		no_idle = 0;
		errors = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset sizes, then a mid-size image with centre, corners and extremes
		add_pixel(0, 0, 255, 255, 255);
		add_pixel(4095, 4095, 255, 255, 255);
		drain_pipe();
		write_reg(rvp_pkg::REG_HEIGHT, 13'd100);
		write_reg(rvp_pkg::REG_WIDTH, 13'd200);
		add_pixel(50, 100, 255, 128, 0);
		add_pixel(50, 100, 0, 0, 0);
		add_pixel(0, 0, 255, 255, 255);
		add_pixel(99, 199, 255, 1, 170);
		add_pixel(50, 199, 255, 255, 255);
		add_pixel(150, 100, 255, 255, 255);
		add_pixel(50, 150, 255, 85, 255);
		add_pixel(4095, 0, 255, 255, 255);
		add_pixel(0, 4095, 255, 255, 255);
		add_pixel(12'haaa, 12'h555, 8'haa, 8'h55, 8'h0f);
		drain_pipe();

		hs = '{0, 8191, 4096, 4097, 1, 2, 4096, 37, 3000, 640};
		ws = '{0, 8191, 4096, 1, 4097, 4096, 2, 53, 64, 480};
		foreach (hs[i]) begin
			write_reg(rvp_pkg::REG_HEIGHT, 13'(hs[i]));
			write_reg(rvp_pkg::REG_WIDTH, 13'(ws[i]));
			add_pixel(eff_dim(13'(hs[i])) / 2, eff_dim(13'(ws[i])) / 2, 255, 255, 255);
			no_idle = (i == 4);
			random_pixels(180,
				eff_dim(13'(hs[i])) + 4 > 4095 ? 4095 : eff_dim(13'(hs[i])) + 4,
				eff_dim(13'(ws[i])) + 4 > 4095 ? 4095 : eff_dim(13'(ws[i])) + 4);
			drain_pipe();
		end
		no_idle = 0;

		if (errors == 0) begin
			$display("radial_vignette_pixel test passed");
		end else begin
			$display("radial_vignette_pixel test failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("radial_vignette_pixel test failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rvp_pkg.sv
hw/rtl/rvp_sqrt_cell.sv
hw/rtl/rvp_div_cell.sv
hw/rtl/radial_vignette_pixel.sv
hw/rtl/rvp_checker.sv
tb/radial_vignette_pixel_tb.sv
